// ----- rtl/core/dms_pkg.sv -----
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types and constants of the delimiter message splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

  // operation codes of an input request
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic REG_SEP_LENGTH = 1'b0;
  localparam logic REG_SEP_BYTES  = 1'b1;

  // configuration reset values (CR LF separator)
  localparam logic [3:0]  SEP_LENGTH_RESET = 4'd2;
  localparam logic [63:0] SEP_BYTES_RESET  = 64'h0000_0000_0000_0D0A;

  // fixed field widths
  localparam int OFFSET_W = 16;
  localparam int SIZE_W   = 17;

  // classified request handed from front to back
  typedef struct packed {
    logic       is_clear;
    logic [7:0] data_byte;
    logic       overflow;
  } q_entry_t;

  // front to queue push port
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

endpackage

`default_nettype wire

// ----- rtl/core/delimiter_message_splitter.sv -----
// ----------------------------------------------------------------------------
// delimiter_message_splitter
// Splits a byte stream into parts that end with a configured separator.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   input     in_valid / in_ready    op, data_byte
//   output    out_valid / out_ready  part_offset, part_bytes, overflow
//   config    cfg_we                 cfg_index, cfg_data
//
// One request per cycle while the output is not stalled; a completing byte
// goes through a queue slot, then the result register, into a part record.
// in_ready drops only when both queue slots are held by a stalled output.
// Reset is synchronous; the block accepts requests the cycle after rst falls.
// Bytes past BUF_BYTES are dropped at the front and set the sticky overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_message_splitter #(
  parameter int BUF_BYTES = 65536,
  parameter int SEP_MAX   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [dms_pkg::OFFSET_W-1:0] part_offset,
  output logic [dms_pkg::SIZE_W-1:0]   part_bytes,
  output logic             overflow,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_data
);
  import dms_pkg::*;

  q_push_t  q_push;
  q_entry_t q_entry;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;

  // request classification
  dms_front #(
    .BUF_BYTES (BUF_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .data_byte (data_byte),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // decoupling queue
  dms_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  // matching and result output
  dms_back #(
    .BUF_BYTES (BUF_BYTES),
    .SEP_MAX   (SEP_MAX)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .part_offset (part_offset),
    .part_bytes  (part_bytes),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dms_front.sv -----
// ----------------------------------------------------------------------------
// dms_front
// Accepts input requests, tracks buffer fill and drops bytes past capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_front #(
  parameter int BUF_BYTES = 65536
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             op,
  input  wire logic [7:0]       data_byte,
  input  wire logic             q_full,
  output dms_pkg::q_push_t      q_push
);
  import dms_pkg::*;

  localparam int PW = $clog2(BUF_BYTES + 1);

  logic [PW-1:0] fill;
  logic          overflow_flag;
  logic          accept;
  logic          full_buf;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign full_buf = (fill >= PW'(BUF_BYTES));

  // classify the request
  always_comb begin
    q_push.push           = 1'b0;
    q_push.entry.is_clear = (op == OP_CLEAR);
    q_push.entry.data_byte = data_byte;
    q_push.entry.overflow = overflow_flag;
    if (accept) begin
      q_push.push = (op == OP_CLEAR) || !full_buf;
    end
  end

  // fill count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      fill          <= '0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      if (op == OP_CLEAR) begin
        fill <= '0;
      end else if (full_buf) begin
        overflow_flag <= 1'b1;
      end else begin
        fill <= fill + PW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dms_queue.sv -----
// ----------------------------------------------------------------------------
// dms_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dms_pkg::q_push_t q_push,
  output logic                  q_full,
  output logic                  q_valid,
  output dms_pkg::q_entry_t     q_entry,
  input  wire logic             q_pop
);
  import dms_pkg::*;

  q_entry_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_entry = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots[wr_ptr] <= q_push.entry;
    end
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (q_push.push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !q_push.push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dms_back.sv -----
// ----------------------------------------------------------------------------
// dms_back
// Holds the separator window, matches the newest byte and emits part records.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_back #(
  parameter int BUF_BYTES = 65536,
  parameter int SEP_MAX   = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [63:0]      cfg_data,
  input  wire logic             q_valid,
  input  wire dms_pkg::q_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [dms_pkg::OFFSET_W-1:0] part_offset,
  output logic [dms_pkg::SIZE_W-1:0]   part_bytes,
  output logic                  overflow
);
  import dms_pkg::*;

  localparam int PW = $clog2(BUF_BYTES + 1);
  localparam int XW = (PW > SIZE_W) ? PW : SIZE_W;
  localparam int SW = 8 * SEP_MAX;

  logic [3:0]    sep_length;
  logic [63:0]   sep_bytes;
  logic [SW-1:0] recent;
  logic [SW-1:0] recent_next;
  logic [PW-1:0] wr_pos;
  logic [PW-1:0] wr_pos_next;
  logic [PW-1:0] part_start;
  logic [PW-1:0] part_len;
  logic [3:0]    eff_len;
  logic          window_ok;
  logic          match;
  logic          take;
  logic [XW-1:0] off_ext;
  logic [XW-1:0] size_ext;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_length <= SEP_LENGTH_RESET;
      sep_bytes  <= SEP_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEP_LENGTH: sep_length <= cfg_data[3:0];
        REG_SEP_BYTES:  sep_bytes  <= cfg_data;
        default:        sep_length <= sep_length;
      endcase
    end
  end

  // effective separator length
  always_comb begin
    priority if (sep_length == 4'd0) begin
      eff_len = 4'd1;
    end else if (sep_length > 4'(SEP_MAX)) begin
      eff_len = 4'(SEP_MAX);
    end else begin
      eff_len = sep_length;
    end
  end

  // window compare on the newest bytes
  assign recent_next = (recent << 8) | SW'(q_entry.data_byte);

  always_comb begin
    window_ok = 1'b1;
    for (int i = 0; i < SEP_MAX; i++) begin
      if ((4'(i) < eff_len) && (recent_next[8*i +: 8] != sep_bytes[8*i +: 8])) begin
        window_ok = 1'b0;
      end
    end
  end

  assign wr_pos_next = wr_pos + PW'(1);
  assign part_len    = wr_pos_next - part_start;
  assign match       = window_ok && (part_len >= PW'(eff_len));

  assign take  = !out_valid || out_ready;
  assign q_pop = q_valid && take;

  // position tracking and window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pos     <= '0;
      part_start <= '0;
    end else if (q_pop) begin
      if (q_entry.is_clear) begin
        wr_pos     <= '0;
        part_start <= '0;
      end else begin
        wr_pos <= wr_pos_next;
        if (match) begin
          part_start <= wr_pos_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_entry.is_clear) begin
      recent <= recent_next;
    end
  end

  // result register
  assign off_ext  = XW'(part_start);
  assign size_ext = XW'(part_len);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= q_pop && !q_entry.is_clear && match;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_entry.is_clear && match) begin
      part_offset <= off_ext[OFFSET_W-1:0];
      part_bytes  <= size_ext[SIZE_W-1:0];
      overflow    <= q_entry.overflow;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dms_checker.sv -----
// ----------------------------------------------------------------------------
// dms_checker
// Port-level checks of the delimiter message splitter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] part_offset,
  input wire logic [16:0] part_bytes,
  input wire logic        overflow
);

  // no result right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // the block is ready for requests right after reset
  assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // a part always holds at least its separator
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (part_bytes != 17'd0))
    else $error("empty part reported");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(part_offset) && $stable(part_bytes) && $stable(overflow)))
    else $error("stalled result changed");

endmodule

bind delimiter_message_splitter dms_checker u_dms_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .part_offset (part_offset),
  .part_bytes  (part_bytes),
  .overflow    (overflow)
);

`default_nettype wire
